// File: design/axis_angle_point_rotation_defines.svh
// Assertion macros used by the rotation pipeline top file.
`ifndef AXIS_ANGLE_POINT_ROTATION_DEFINES_SVH
`define AXIS_ANGLE_POINT_ROTATION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AAPR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aapr check failed");

// Next-cycle implication, disabled during reset.
`define AAPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aapr check failed");

`endif

// File: design/aapr_pkg.sv
// Types, constants and the quarter-wave sine table of the rotation pipeline.
package aapr_pkg;

  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int COEF_FRAC_BITS = 14;

  localparam int SINE_ADDR_W = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int SINE_W = COEF_FRAC_BITS + 1;
  localparam int TRIG_W = COEF_FRAC_BITS + 2;
  localparam int OMC_W = COEF_FRAC_BITS + 3;
  localparam int MAT_W = COEF_FRAC_BITS + 34;
  localparam int COEF_W = COEF_FRAC_BITS + 6;
  localparam int ACC_W = COEF_W + 34;

  // Angle reduction: full turn is 92160 = 2^11 * 45, quarter is 23040 = 2^9 * 45.
  localparam int ANGLE_OFFSET = 92 * 92160;
  localparam int RECIP45_V = (1 << 20) / 45;
  localparam int RECIP45_T = (1 << 24) / 45;
  localparam int HALF_QUARTER = 11520;
  localparam int TPROD_W = SINE_ADDR_W + 16;
  localparam int T_W = TPROD_W - 9;
  localparam int KPROD_W = T_W + 19;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [23:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef logic [SINE_W-1:0] sine_tab_t [SINE_TABLE_ENTRIES + 1];

  // Taylor series of sin(pi/2 * k/N) in Q30, rounded to Q.F.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x = (64'd1686629713 * 64'(k) + 64'(SINE_TABLE_ENTRIES / 2)) / 64'(SINE_TABLE_ENTRIES);
      x2 = (x * x) >> 30;
      sum = x;
      term = x;
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd506; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd600; sum = sum + term;
      tab[k] = SINE_W'((sum + (64'd1 << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// File: design/axis_angle_point_rotation.sv
// An accepted item passes through the angle, matrix and apply stages to the output register.
// Throughput: one item per cycle unless stalled; two sine RAM read ports per item.
// A result stalled at the output freezes the whole pipeline without loss.
// Reset (rst, synchronous) clears all valid bits, then the sine table is filled
// from ROM, one entry a cycle, with point_stall high until every entry is written.
`include "axis_angle_point_rotation_defines.svh"
module axis_angle_point_rotation (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   point_valid,
  output logic                   point_stall,
  input  aapr_pkg::in_item_t     point_item,
  output logic                   rotated_valid,
  input  logic                   rotated_stall,
  output aapr_pkg::out_item_t    rotated_item
);
  import aapr_pkg::*;

  logic               advance;
  logic               fill_busy;
  logic               ang_valid;
  in_item_t           ang_item;
  trig_t              ang_trig;
  logic               mat_valid;
  logic signed [31:0] mat_px;
  logic signed [31:0] mat_py;
  logic signed [31:0] mat_pz;
  coef_t [8:0]        mat_coef;

  // Global pipeline enable: hold everything while the output item waits
  assign advance = !(rotated_valid && rotated_stall);
  assign point_stall = fill_busy || !advance;

  aapr_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (point_valid && !point_stall),
    .in_item   (point_item),
    .fill_busy (fill_busy),
    .out_valid (ang_valid),
    .out_item  (ang_item),
    .out_trig  (ang_trig)
  );

  aapr_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (ang_valid),
    .in_item   (ang_item),
    .in_trig   (ang_trig),
    .out_valid (mat_valid),
    .out_px    (mat_px),
    .out_py    (mat_py),
    .out_pz    (mat_pz),
    .out_coef  (mat_coef)
  );

  aapr_apply u_apply (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (mat_valid),
    .in_px     (mat_px),
    .in_py     (mat_py),
    .in_pz     (mat_pz),
    .in_coef   (mat_coef),
    .out_valid (rotated_valid),
    .out_item  (rotated_item)
  );

  // No item enters while the table is still being filled
  `AAPR_ASSERT_NOW(a_fill_blocks_input, clk, rst, fill_busy, point_stall)
  // Fill always starts right after reset
  `AAPR_ASSERT_NOW(a_fill_after_reset, clk, rst, $past(rst), fill_busy)
  // A flagged result has at least one coordinate at a rail
  `AAPR_ASSERT_NOW(a_sat_at_rail, clk, rst, rotated_valid && rotated_item.saturated,
    (rotated_item.rotated_x == 32'sh7fff_ffff) || (rotated_item.rotated_x == 32'sh8000_0000) ||
    (rotated_item.rotated_y == 32'sh7fff_ffff) || (rotated_item.rotated_y == 32'sh8000_0000) ||
    (rotated_item.rotated_z == 32'sh7fff_ffff) || (rotated_item.rotated_z == 32'sh8000_0000))

endmodule

// File: design/aapr_ram.sv
// Generic RAM: one write port, two registered read ports.
module aapr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: design/aapr_angle.sv
// Angle reduction, sine table lookup and quadrant mapping (six stages).
module aapr_angle (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  aapr_pkg::in_item_t in_item,
  output logic               fill_busy,
  output logic               out_valid,
  output aapr_pkg::in_item_t out_item,
  output aapr_pkg::trig_t    out_trig
);
  import aapr_pkg::*;

  function automatic logic [24:0] angle_sx(input logic [23:0] a);
    return {a[23], a};
  endfunction

  // Table fill after reset
  logic [SINE_ADDR_W-1:0] fill_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_addr <= '0;
      fill_busy <= 1'b1;
    end else if (fill_busy) begin
      if (fill_addr == SINE_ADDR_W'(SINE_TABLE_ENTRIES)) begin
        fill_busy <= 1'b0;
      end else begin
        fill_addr <= fill_addr + 1'b1;
      end
    end
  end

  // Stage 1: offset angle positive, estimate turns / 45 on upper bits
  logic [24:0] ang_pos;
  logic [28:0] vprod;
  logic        v1;
  in_item_t    item1;
  logic [13:0] vhi1;
  logic [10:0] lo1;
  logic [7:0]  qa1;

  assign ang_pos = {angle_sx(in_item.angle)} + 25'(ANGLE_OFFSET);
  assign vprod = 29'(ang_pos[24:11]) * 29'(RECIP45_V);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item1 <= in_item;
      vhi1 <= ang_pos[24:11];
      lo1 <= ang_pos[10:0];
      qa1 <= vprod[27:20];
    end
  end

  // Stage 2: remainder mod full turn, quadrant and phase
  logic [13:0]  rm_raw;
  logic [5:0]   rm;
  logic [7:0]   w;
  logic [1:0]   quad;
  logic [7:0]   wr;
  logic         v2;
  in_item_t     item2;
  logic [1:0]   quad2;
  logic [14:0]  ph2;

  assign rm_raw = vhi1 - 14'(qa1) * 14'd45;
  assign rm = (rm_raw >= 14'd45) ? 6'(rm_raw - 14'd45) : 6'(rm_raw);
  assign w = {rm, lo1[10:9]};

  always_comb begin
    if (w >= 8'd135) begin
      quad = 2'd3;
      wr = w - 8'd135;
    end else if (w >= 8'd90) begin
      quad = 2'd2;
      wr = w - 8'd90;
    end else if (w >= 8'd45) begin
      quad = 2'd1;
      wr = w - 8'd45;
    end else begin
      quad = 2'd0;
      wr = w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item2 <= item1;
      quad2 <= quad;
      ph2 <= {wr[5:0], lo1[8:0]};
    end
  end

  // Stage 3: scaled phase over 512
  logic [TPROD_W-1:0] tprod;
  logic               v3;
  in_item_t           item3;
  logic [1:0]         quad3;
  logic [T_W-1:0]     t3;

  assign tprod = TPROD_W'(ph2) * TPROD_W'(SINE_TABLE_ENTRIES) + TPROD_W'(HALF_QUARTER);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item3 <= item2;
      quad3 <= quad2;
      t3 <= tprod[TPROD_W-1:9];
    end
  end

  // Stage 4: index estimate, t / 45 by reciprocal
  logic [KPROD_W-1:0]     kprod;
  logic                   v4;
  in_item_t               item4;
  logic [1:0]             quad4;
  logic [T_W-1:0]         t4;
  logic [SINE_ADDR_W-1:0] kq4;

  assign kprod = KPROD_W'(t3) * KPROD_W'(RECIP45_T);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (advance) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item4 <= item3;
      quad4 <= quad3;
      t4 <= t3;
      kq4 <= kprod[24 +: SINE_ADDR_W];
    end
  end

  // Stage 5: index correction and table read
  logic [T_W-1:0]         kr;
  logic [SINE_ADDR_W-1:0] k;
  logic [SINE_W-1:0]      sin_a;
  logic [SINE_W-1:0]      sin_b;
  logic                   v5;
  in_item_t               item5;
  logic [1:0]             quad5;

  assign kr = t4 - T_W'(kq4) * T_W'(45);
  assign k = (kr >= T_W'(45)) ? kq4 + 1'b1 : kq4;

  aapr_ram #(
    .WIDTH(SINE_W),
    .DEPTH(SINE_TABLE_ENTRIES + 1)
  ) u_sine_ram (
    .clk     (clk),
    .we      (fill_busy),
    .waddr   (fill_addr),
    .wdata   (SINE_TAB[fill_addr]),
    .re      (advance),
    .raddr_a (k),
    .raddr_b (SINE_ADDR_W'(SINE_TABLE_ENTRIES) - k),
    .rdata_a (sin_a),
    .rdata_b (sin_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (advance) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item5 <= item4;
      quad5 <= quad4;
    end
  end

  // Stage 6: quadrant mapping of the sine/cosine pair
  logic signed [TRIG_W-1:0] a_s;
  logic signed [TRIG_W-1:0] b_s;
  trig_t                    trig;

  assign a_s = signed'({1'b0, sin_a});
  assign b_s = signed'({1'b0, sin_b});

  always_comb begin
    case (quad5)
      2'd0: begin
        trig.s = a_s;
        trig.c = b_s;
      end
      2'd1: begin
        trig.s = b_s;
        trig.c = -a_s;
      end
      2'd2: begin
        trig.s = -a_s;
        trig.c = -b_s;
      end
      default: begin
        trig.s = -b_s;
        trig.c = a_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item5;
      out_trig <= trig;
    end
  end

endmodule

// File: design/aapr_matrix.sv
// Rodrigues rotation matrix build and coefficient rounding (two stages).
module aapr_matrix (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    in_valid,
  input  aapr_pkg::in_item_t      in_item,
  input  aapr_pkg::trig_t         in_trig,
  output logic                    out_valid,
  output logic signed [31:0]      out_px,
  output logic signed [31:0]      out_py,
  output logic signed [31:0]      out_pz,
  output aapr_pkg::coef_t [8:0]   out_coef
);
  import aapr_pkg::*;

  // Stage 1: axis outer product, axis times sine, one minus cosine
  logic signed [15:0]          u [3];
  logic                        v1;
  logic signed [31:0]          uu1 [9];
  logic signed [TRIG_W+15:0]   us1 [3];
  logic signed [TRIG_W-1:0]    c1;
  logic signed [OMC_W-1:0]     omc1;
  logic signed [31:0]          p1 [3];

  assign u[0] = in_item.axis_x;
  assign u[1] = in_item.axis_y;
  assign u[2] = in_item.axis_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          uu1[i*3+j] <= 32'(u[i]) * 32'(u[j]);
        end
        us1[i] <= (TRIG_W+16)'(u[i]) * (TRIG_W+16)'(in_trig.s);
      end
      c1 <= in_trig.c;
      omc1 <= (OMC_W'(1) <<< COEF_FRAC_BITS) - OMC_W'(in_trig.c);
      p1[0] <= in_item.point_x;
      p1[1] <= in_item.point_y;
      p1[2] <= in_item.point_z;
    end
  end

  // Stage 2: full-precision matrix, rounded half up to Q.F
  logic signed [MAT_W-1:0] m [9];
  logic signed [MAT_W-1:0] cdiag;
  logic signed [MAT_W-1:0] cr [3];

  assign cdiag = MAT_W'(c1) <<< 28;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = MAT_W'(us1[i]) <<< 14;
    end
    for (int i = 0; i < 9; i++) begin
      m[i] = MAT_W'(uu1[i]) * MAT_W'(omc1);
    end
    m[0] = m[0] + cdiag;
    m[4] = m[4] + cdiag;
    m[8] = m[8] + cdiag;
    m[1] = m[1] - cr[2];
    m[2] = m[2] + cr[1];
    m[3] = m[3] + cr[2];
    m[5] = m[5] - cr[0];
    m[6] = m[6] - cr[1];
    m[7] = m[7] + cr[0];
    for (int i = 0; i < 9; i++) begin
      m[i] = m[i] + (MAT_W'(1) <<< 27);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 9; i++) begin
        out_coef[i] <= m[i][MAT_W-1:28];
      end
      out_px <= p1[0];
      out_py <= p1[1];
      out_pz <= p1[2];
    end
  end

endmodule

// File: design/aapr_apply.sv
// Matrix times point, rounding and saturation to Q16.16 (two stages).
module aapr_apply (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   in_valid,
  input  logic signed [31:0]     in_px,
  input  logic signed [31:0]     in_py,
  input  logic signed [31:0]     in_pz,
  input  aapr_pkg::coef_t [8:0]  in_coef,
  output logic                   out_valid,
  output aapr_pkg::out_item_t    out_item
);
  import aapr_pkg::*;

  // Stage 1: nine products
  logic signed [31:0]      p [3];
  logic                    v1;
  logic signed [ACC_W-1:0] prod1 [9];

  assign p[0] = in_px;
  assign p[1] = in_py;
  assign p[2] = in_pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod1[i*3+j] <= ACC_W'(in_coef[i*3+j]) * ACC_W'(p[j]);
        end
      end
    end
  end

  // Stage 2: row sums, round half up, clip
  logic signed [ACC_W-1:0] acc [3];
  logic signed [ACC_W-1:0] rnd [3];
  logic [2:0]              ovf;
  logic signed [31:0]      res [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = prod1[i*3] + prod1[i*3+1] + prod1[i*3+2]
             + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
      rnd[i] = acc[i] >>> COEF_FRAC_BITS;
      ovf[i] = !((rnd[i][ACC_W-1:31] == '0) || (rnd[i][ACC_W-1:31] == '1));
      if (!ovf[i]) begin
        res[i] = rnd[i][31:0];
      end else if (rnd[i][ACC_W-1]) begin
        res[i] = 32'sh8000_0000;
      end else begin
        res[i] = 32'sh7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.rotated_x <= res[0];
      out_item.rotated_y <= res[1];
      out_item.rotated_z <= res[2];
      out_item.saturated <= |ovf;
    end
  end

endmodule

// File: tb/sv/axis_angle_point_rotation_tb.sv
// Self-checking testbench for the fixed-point axis-angle point rotation pipeline.
module axis_angle_point_rotation_tb;
  import aapr_pkg::*;

  localparam int QUARTER_UNITS = 23040;
  localparam int FULL_UNITS = 92160;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  logic point_stall;
  in_item_t point_item = '0;
  logic rotated_valid;
  logic rotated_stall = 1'b0;
  out_item_t rotated_item;

  in_item_t pending_points[$];
  out_item_t expected_rotations[$];
  logic [SINE_W-1:0] sine_quarter[SINE_TABLE_ENTRIES + 1];
  int errors = 0;
  int cycles = 0;
  bit stimulus_loaded = 1'b0;
  bit quiet_phase = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  axis_angle_point_rotation DUT (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point_item(point_item),
    .rotated_valid(rotated_valid), .rotated_stall(rotated_stall),
    .rotated_item(rotated_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Quarter-wave sine table from a truncated Taylor series in Q30
  function automatic logic [SINE_W-1:0] series_sine(int k);
    logic [63:0] x, x2, term, sum;
    x = (64'd1686629713 * 64'(k) + 64'(SINE_TABLE_ENTRIES / 2)) / 64'(SINE_TABLE_ENTRIES);
    x2 = (x * x) >> 30;
    sum = x;
    term = x;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return SINE_W'((sum + (64'd1 << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS));
  endfunction

  function automatic longint round_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // Rodrigues rotation: R = c*I + (1-c)*u*u^T + s*[u]x, applied to the point
  function automatic out_item_t rotate_point(in_item_t it);
    out_item_t res;
    longint p[3], u[3], m[9];
    longint r, q, ph, k, a, b, s, c, omc, acc, v;
    p[0] = it.point_x; p[1] = it.point_y; p[2] = it.point_z;
    u[0] = it.axis_x; u[1] = it.axis_y; u[2] = it.axis_z;
    r = longint'(it.angle) % FULL_UNITS;
    if (r < 0) r += FULL_UNITS;
    q = r / QUARTER_UNITS;
    ph = r % QUARTER_UNITS;
    k = (ph * SINE_TABLE_ENTRIES + QUARTER_UNITS / 2) / QUARTER_UNITS;
    a = sine_quarter[k];
    b = sine_quarter[SINE_TABLE_ENTRIES - k];
    case (q)
      0: begin s = a; c = b; end
      1: begin s = b; c = -a; end
      2: begin s = -a; c = -b; end
      default: begin s = -b; c = a; end
    endcase
    omc = (64'sd1 <<< COEF_FRAC_BITS) - c;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i * 3 + j] = u[i] * u[j] * omc;
    for (int i = 0; i < 3; i++) m[i * 4] += c * (64'sd1 <<< 28);
    m[1] -= u[2] * s * 16384;
    m[2] += u[1] * s * 16384;
    m[3] += u[2] * s * 16384;
    m[5] -= u[0] * s * 16384;
    m[6] -= u[1] * s * 16384;
    m[7] += u[0] * s * 16384;
    for (int i = 0; i < 9; i++) m[i] = round_shift(m[i], 28);
    res.saturated = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = m[i * 3] * p[0] + m[i * 3 + 1] * p[1] + m[i * 3 + 2] * p[2];
      v = round_shift(acc, COEF_FRAC_BITS);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647; res.saturated = 1'b1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648; res.saturated = 1'b1;
      end
      if (i == 0) res.rotated_x = v[31:0];
      else if (i == 1) res.rotated_y = v[31:0];
      else res.rotated_z = v[31:0];
    end
    return res;
  endfunction

  function automatic in_item_t make_point(int px, int py, int pz, int ax, int ay, int az,
                                          int ang);
    in_item_t it;
    it.point_x = px; it.point_y = py; it.point_z = pz;
    it.axis_x = 16'(ax); it.axis_y = 16'(ay); it.axis_z = 16'(az);
    it.angle = 24'(ang);
    return it;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  // Random axis: mostly components within +-16384 (unit), sometimes any 16-bit value
  function automatic in_item_t rand_point();
    in_item_t it;
    int ax, ay, az;
    it.point_x = rand_coord(); it.point_y = rand_coord(); it.point_z = rand_coord();
    if ($urandom_range(0, 4) == 0) begin
      ax = $urandom; ay = $urandom; az = $urandom;
    end else begin
      ax = $signed($urandom_range(0, 32768)) - 16384;
      ay = $signed($urandom_range(0, 32768)) - 16384;
      az = $signed($urandom_range(0, 32768)) - 16384;
      case ($urandom_range(0, 3))
        0: begin ay = 0; az = 0; ax = $urandom_range(0, 1) ? 16384 : -16384; end
        1: ay = 0;
        default: ;
      endcase
    end
    it.axis_x = 16'(ax); it.axis_y = 16'(ay); it.axis_z = 16'(az);
    if ($urandom_range(0, 1)) it.angle = 24'($urandom);
    else it.angle = 24'($signed($urandom_range(0, 2 * FULL_UNITS)) - FULL_UNITS);
    return it;
  endfunction

  // Directed points, then random ones
  initial begin
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) sine_quarter[k] = series_sine(k);
    pending_points.push_back(make_point(65536, 0, 0, 0, 0, 16384, 0));
    pending_points.push_back(make_point(65536, 0, 0, 0, 0, 16384, QUARTER_UNITS));
    pending_points.push_back(make_point(65536, 65536, 0, 0, 0, 16384, 2 * QUARTER_UNITS));
    pending_points.push_back(make_point(0, 65536, 0, 16384, 0, 0, 3 * QUARTER_UNITS));
    pending_points.push_back(make_point(0, 0, 65536, 0, 16384, 0, FULL_UNITS));
    pending_points.push_back(make_point(65536, 65536, 65536, 0, 0, 0, 11520));
    pending_points.push_back(make_point(-1, -1, -1, -16384, -16384, -16384, -1));
    pending_points.push_back(make_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                        9459, 9459, 9459, 30720));
    pending_points.push_back(make_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                        0, 0, 16384, 11520));
    pending_points.push_back(make_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                                        16384, 16384, 16384, 5000));
    pending_points.push_back(make_point(123456, -654321, 777, 16'sh7FFF, 16'sh8000,
                                        16'sh7FFF, 24'sh7FFFFF));
    pending_points.push_back(make_point(1 << 20, 0, -(1 << 20), 16'sh8000, 16'sh8000,
                                        16'sh8000, 24'sh800000));
    pending_points.push_back(make_point(65536, 0, 0, 11585, 0, 11585, 45));
    pending_points.push_back(make_point(65536, 0, 0, 11585, 0, 11585, -45));
    pending_points.push_back(make_point(-65536, 32768, 3, 0, -16384, 0, 23039));
    pending_points.push_back(make_point(65536, 0, 0, 0, 0, 16384, 46079));
    for (int n = 0; n < RANDOM_ITEMS; n++) pending_points.push_back(rand_point());
    stimulus_loaded = 1'b1;
  end

  // Reset, cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 11) rst <= 1'b0;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Driver with random idle bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (point_valid && !point_stall) begin
        expected_rotations.push_back(rotate_point(point_item));
      end
      if (!point_valid || !point_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          point_valid <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 14);
          point_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          point_item <= pending_points.pop_front();
          point_valid <= 1'b1;
        end else begin
          point_valid <= 1'b0;
        end
      end
      quiet_phase <= stimulus_loaded && pending_points.size() < 150;
    end
  end

  // Receiver stalls and result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rotated_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 14);
        rotated_stall <= 1'b1;
      end else begin
        rotated_stall <= 1'b0;
      end
      if (rotated_valid && !rotated_stall) begin
        if (expected_rotations.size() == 0) begin
          $error("unexpected rotated item %p", rotated_item);
          errors++;
        end else begin
          want = expected_rotations.pop_front();
          if (rotated_item.rotated_x !== want.rotated_x) begin
            $error("rotated_x expected %0d actual %0d", want.rotated_x, rotated_item.rotated_x);
            errors++;
          end
          if (rotated_item.rotated_y !== want.rotated_y) begin
            $error("rotated_y expected %0d actual %0d", want.rotated_y, rotated_item.rotated_y);
            errors++;
          end
          if (rotated_item.rotated_z !== want.rotated_z) begin
            $error("rotated_z expected %0d actual %0d", want.rotated_z, rotated_item.rotated_z);
            errors++;
          end
          if (rotated_item.saturated !== want.saturated) begin
            $error("saturated expected %0b actual %0b", want.saturated, rotated_item.saturated);
            errors++;
          end
        end
      end
    end
  end

  // End of run: all items sent, all results back, then drain
  initial begin
    wait (stimulus_loaded && !rst);
    wait (pending_points.size() == 0 && !point_valid && expected_rotations.size() == 0);
    repeat (30) @(posedge clk);
    if (errors == 0 && expected_rotations.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
